/* sv/ptt_pkg.sv */
// ----------------------------------------------------------------------------
// ptt_pkg
// Shared types and constants for the property list text tokenizer: lexer
// modes, lexer state, token layout, token kinds, error codes and characters.
// ----------------------------------------------------------------------------
package ptt_pkg;

  // Lexer modes
  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINE_CMT,
    MODE_BLOCK_CMT,
    MODE_STAR,
    MODE_UNQUOTED,
    MODE_QUOTED,
    MODE_ESC,
    MODE_NUM
  } mode_t;

  // Token kinds
  localparam logic [2:0] KIND_DATA  = 3'd0;
  localparam logic [2:0] KIND_END   = 3'd1;
  localparam logic [2:0] KIND_PUNCT = 3'd2;
  localparam logic [2:0] KIND_OTHER = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;
  localparam logic [2:0] KIND_EOI   = 3'd5;

  // Error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_COMMENT = 2'd1;
  localparam logic [1:0] ERR_QUOTED  = 2'd2;
  localparam logic [1:0] ERR_BINARY  = 2'd3;

  // Characters
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_SEVEN  = 8'h37;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;

  // Most results one item can cause
  localparam int MAX_RESULTS = 4;
  localparam int CNT_BITS    = 3;

  // Width of the line number on the output
  localparam int LINE_OUT_BITS = 20;

  typedef struct packed {
    mode_t      mode;
    logic [7:0] esc_value;
    logic       hex_escape;
    logic       first_digit;
  } lex_state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] value;
    logic       quoted;
    logic [1:0] err;
  } token_t;

endpackage

/* sv/ptt_lexer.sv */
// ----------------------------------------------------------------------------
// ptt_lexer
// Combinational lexer step: takes the current lexer state and one text byte,
// gives the next state and up to four tokens, packed from slot zero up.
// ----------------------------------------------------------------------------
module ptt_lexer (
  input  ptt_pkg::lex_state_t state,
  input  logic [7:0]          text_byte,
  input  logic                final_byte,
  output ptt_pkg::lex_state_t state_next,
  output ptt_pkg::token_t     tok [ptt_pkg::MAX_RESULTS],
  output logic [ptt_pkg::CNT_BITS-1:0] tok_cnt
);
  import ptt_pkg::*;

  typedef struct packed {
    logic       put;
    token_t     tok;
    lex_state_t st;
    logic       again;
  } step_t;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h7A) ||
           (c >= 8'h41 && c <= 8'h5A);
  endfunction

  function automatic logic is_punct(logic [7:0] c);
    return (c == 8'h7B) || (c == 8'h7D) || (c == 8'h28) || (c == 8'h29) ||
           (c == 8'h3D) || (c == 8'h3B) || (c == 8'h2C);
  endfunction

  // Valid flag in the top bit, digit value below
  function automatic logic [4:0] hex_val(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
    else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
    return r;
  endfunction

  function automatic logic [7:0] esc_map(logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h74:   r = 8'd9;
      8'h72:   r = 8'd13;
      8'h6E:   r = 8'd10;
      8'h76:   r = 8'd11;
      8'h66:   r = 8'd12;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic token_t mk_tok(logic [2:0] kind, logic [7:0] value, logic quoted,
                                    logic [1:0] err);
    token_t t;
    t.kind   = kind;
    t.value  = value;
    t.quoted = quoted;
    t.err    = err;
    return t;
  endfunction

  // One pass of the lexer over the byte
  function automatic step_t lex_step(lex_state_t s, logic [7:0] c);
    step_t      r;
    logic [4:0] h;
    r.put   = 1'b0;
    r.tok   = '0;
    r.st    = s;
    r.again = 1'b0;
    h       = hex_val(c);
    case (s.mode)
      MODE_SLASH: begin
        if (c == CH_SLASH) r.st.mode = MODE_LINE_CMT;
        else if (c == CH_STAR) r.st.mode = MODE_BLOCK_CMT;
        else begin
          r.put     = 1'b1;
          r.tok     = mk_tok(KIND_OTHER, CH_SLASH, 1'b0, ERR_NONE);
          r.st.mode = MODE_IDLE;
          r.again   = 1'b1;
        end
      end
      MODE_LINE_CMT: begin
        if (c == CH_LF) r.st.mode = MODE_IDLE;
      end
      MODE_BLOCK_CMT: begin
        if (c == CH_STAR) r.st.mode = MODE_STAR;
      end
      MODE_STAR: begin
        if (c == CH_SLASH) r.st.mode = MODE_IDLE;
        else if (c != CH_STAR) r.st.mode = MODE_BLOCK_CMT;
      end
      MODE_UNQUOTED: begin
        r.put = 1'b1;
        if (is_alnum(c)) r.tok = mk_tok(KIND_DATA, c, 1'b0, ERR_NONE);
        else begin
          r.tok     = mk_tok(KIND_END, 8'd0, 1'b0, ERR_NONE);
          r.st.mode = MODE_IDLE;
          r.again   = 1'b1;
        end
      end
      MODE_QUOTED: begin
        if (c == CH_BSLASH) r.st.mode = MODE_ESC;
        else if (c == CH_QUOTE) begin
          r.put     = 1'b1;
          r.tok     = mk_tok(KIND_END, 8'd0, 1'b1, ERR_NONE);
          r.st.mode = MODE_IDLE;
        end else begin
          r.put = 1'b1;
          r.tok = mk_tok(KIND_DATA, c, 1'b1, ERR_NONE);
        end
      end
      MODE_ESC: begin
        if (c == CH_ZERO) begin
          r.st.esc_value   = 8'd0;
          r.st.hex_escape  = 1'b0;
          r.st.first_digit = 1'b1;
          r.st.mode        = MODE_NUM;
        end else begin
          r.put     = 1'b1;
          r.tok     = mk_tok(KIND_DATA, esc_map(c), 1'b1, ERR_NONE);
          r.st.mode = MODE_QUOTED;
        end
      end
      MODE_NUM: begin
        if (s.first_digit && c == CH_X) begin
          r.st.hex_escape  = 1'b1;
          r.st.first_digit = 1'b0;
        end else if (s.hex_escape && h[4]) begin
          r.st.esc_value   = {s.esc_value[3:0], h[3:0]};
          r.st.first_digit = 1'b0;
        end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
          r.st.esc_value   = {s.esc_value[4:0], c[2:0]};
          r.st.first_digit = 1'b0;
        end else begin
          // Value ends: emit it and lex the byte again inside the string
          r.put            = 1'b1;
          r.tok            = mk_tok(KIND_DATA, s.esc_value, 1'b1, ERR_NONE);
          r.st.esc_value   = 8'd0;
          r.st.hex_escape  = 1'b0;
          r.st.first_digit = 1'b0;
          r.st.mode        = MODE_QUOTED;
          r.again          = 1'b1;
        end
      end
      default: begin
        r.st.mode = MODE_IDLE;
        if (is_space(c)) r.st.mode = MODE_IDLE;
        else if (c == CH_SLASH) r.st.mode = MODE_SLASH;
        else if (c == CH_QUOTE) r.st.mode = MODE_QUOTED;
        else if (c == CH_LT) begin
          r.put = 1'b1;
          r.tok = mk_tok(KIND_ERROR, CH_LT, 1'b0, ERR_BINARY);
        end else if (is_alnum(c)) begin
          r.put     = 1'b1;
          r.tok     = mk_tok(KIND_DATA, c, 1'b0, ERR_NONE);
          r.st.mode = MODE_UNQUOTED;
        end else if (is_punct(c)) begin
          r.put = 1'b1;
          r.tok = mk_tok(KIND_PUNCT, c, 1'b0, ERR_NONE);
        end else begin
          r.put = 1'b1;
          r.tok = mk_tok(KIND_OTHER, c, 1'b0, ERR_NONE);
        end
      end
    endcase
    return r;
  endfunction

  step_t      pass1;
  step_t      pass2;
  lex_state_t mid;
  logic       fin_put0;
  logic       fin_put1;
  token_t     fin_tok0;
  token_t     fin_tok1;
  logic       cand_put [MAX_RESULTS];
  token_t     cand_tok [MAX_RESULTS];

  // Run the first pass, and a second one when the byte is lexed again
  always_comb begin
    pass1 = lex_step(state, text_byte);
    pass2 = lex_step(pass1.st, text_byte);
    if (!pass1.again) begin
      pass2.put = 1'b0;
      pass2.st  = pass1.st;
    end
    mid = pass2.st;
  end

  // Close the text on the final byte
  always_comb begin
    fin_put0   = 1'b0;
    fin_put1   = 1'b0;
    fin_tok0   = '0;
    fin_tok1   = mk_tok(KIND_EOI, 8'd0, 1'b0, ERR_NONE);
    state_next = mid;
    if (final_byte) begin
      state_next = '0;
      state_next.mode = MODE_IDLE;
      fin_put1 = 1'b1;
      case (mid.mode)
        MODE_LINE_CMT, MODE_BLOCK_CMT, MODE_STAR:
          fin_tok1 = mk_tok(KIND_ERROR, 8'd0, 1'b0, ERR_COMMENT);
        MODE_QUOTED, MODE_ESC, MODE_NUM:
          fin_tok1 = mk_tok(KIND_ERROR, 8'd0, 1'b0, ERR_QUOTED);
        MODE_SLASH: begin
          fin_put0 = 1'b1;
          fin_tok0 = mk_tok(KIND_OTHER, CH_SLASH, 1'b0, ERR_NONE);
        end
        MODE_UNQUOTED: begin
          fin_put0 = 1'b1;
          fin_tok0 = mk_tok(KIND_END, 8'd0, 1'b0, ERR_NONE);
        end
        default: fin_put0 = 1'b0;
      endcase
    end
  end

  // Pack the tokens that were produced into the low slots
  always_comb begin
    cand_put[0] = pass1.put;
    cand_tok[0] = pass1.tok;
    cand_put[1] = pass2.put;
    cand_tok[1] = pass2.tok;
    cand_put[2] = fin_put0;
    cand_tok[2] = fin_tok0;
    cand_put[3] = fin_put1;
    cand_tok[3] = fin_tok1;
    tok_cnt = '0;
    for (int k = 0; k < MAX_RESULTS; k++) tok[k] = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (cand_put[k]) begin
        tok[tok_cnt[1:0]] = cand_tok[k];
        tok_cnt = tok_cnt + 3'd1;
      end
    end
  end

endmodule

/* sv/plist_text_tokenizer.sv */
// An item is taken into the input register and lexed from there into the result
// buffer, whose results go out on m_axis one result per cycle while m_axis_tready is high.
// Throughput: one item per cycle while the eight-entry result buffer has room for
// four results; each result of an item takes its own output handshake.
// Reset: rst (synchronous) returns the lexer to idle, the line count to one and
// empties the input register and the result buffer.
// ----------------------------------------------------------------------------
// plist_text_tokenizer
// Streaming lexer for text property lists: skips whitespace and comments,
// counts lines, and emits punctuation, string data, end, error, other and end-of-text tokens.
// ----------------------------------------------------------------------------
module plist_text_tokenizer #(
  parameter int LINE_BITS = 20
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic        s_axis_tlast,   // final_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] value_byte, [27:8] line_number,
                                      // [29:28] error_code, [31:30] zero
  output logic [3:0]  m_axis_tuser,   // [2:0] token_kind, [3] from_quotes
  output logic        m_axis_tlast    // run_last
);
  import ptt_pkg::*;

  localparam int FIFO_DEPTH = 8;
  localparam int PTR_BITS   = $clog2(FIFO_DEPTH);
  localparam int FILL_BITS  = PTR_BITS + 1;
  localparam logic [FILL_BITS-1:0] FILL_LIMIT = FILL_BITS'(FIFO_DEPTH - MAX_RESULTS);

  typedef struct packed {
    token_t                   tok;
    logic [LINE_OUT_BITS-1:0] line;
    logic                     last;
  } entry_t;

  // Input register
  logic       ivalid;
  logic [7:0] ibyte;
  logic       ifinal;
  logic       go;

  // Lexer state
  lex_state_t           state;
  lex_state_t           state_next;
  logic [LINE_BITS-1:0] line_count;
  logic [LINE_BITS-1:0] line_cur;
  logic [31:0]          line_wide;

  token_t              tok [MAX_RESULTS];
  logic [CNT_BITS-1:0] tok_cnt;

  // Result buffer
  entry_t               mem [FIFO_DEPTH];
  logic [PTR_BITS-1:0]  wptr;
  logic [PTR_BITS-1:0]  rptr;
  logic [FILL_BITS-1:0] fill;
  logic [FILL_BITS-1:0] fill_next;
  logic                 pop;
  entry_t               head;

  assign go            = ivalid && (fill <= FILL_LIMIT);
  assign s_axis_tready = !ivalid || go;

  // Hold the accepted item until the lexer takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      ivalid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      ivalid <= 1'b1;
    end else if (go) begin
      ivalid <= 1'b0;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      ibyte  <= s_axis_tdata;
      ifinal <= s_axis_tlast;
    end
  end

  ptt_lexer u_lexer (
    .state      (state),
    .text_byte  (ibyte),
    .final_byte (ifinal),
    .state_next (state_next),
    .tok        (tok),
    .tok_cnt    (tok_cnt)
  );

  // Count line feeds, saturating at the top
  always_comb begin
    line_cur = line_count;
    if (ibyte == CH_LF && line_count != {LINE_BITS{1'b1}}) begin
      line_cur = line_count + LINE_BITS'(1);
    end
    line_wide = 32'(line_cur);
  end

  // Advance the lexer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= '{mode: MODE_IDLE, esc_value: 8'd0, hex_escape: 1'b0, first_digit: 1'b0};
      line_count <= LINE_BITS'(1);
    end else if (go) begin
      state      <= state_next;
      line_count <= ifinal ? LINE_BITS'(1) : line_cur;
    end
  end

  // Result buffer bookkeeping
  assign pop  = m_axis_tvalid && m_axis_tready;
  assign head = mem[rptr];

  always_comb begin
    fill_next = fill;
    if (go) fill_next = fill_next + FILL_BITS'(tok_cnt);
    if (pop) fill_next = fill_next - FILL_BITS'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      fill <= fill_next;
      if (go) wptr <= wptr + PTR_BITS'(tok_cnt);
      if (pop) rptr <= rptr + PTR_BITS'(1);
    end
  end

  // Write this item's results into consecutive buffer entries
  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (go && (CNT_BITS'(k) < tok_cnt)) begin
        mem[wptr + PTR_BITS'(k)].tok  <= tok[k];
        mem[wptr + PTR_BITS'(k)].line <= line_wide[LINE_OUT_BITS-1:0];
        mem[wptr + PTR_BITS'(k)].last <= (CNT_BITS'(k + 1) == tok_cnt);
      end
    end
  end

  // Drive the output stream from the buffer head
  assign m_axis_tvalid = (fill != '0);
  assign m_axis_tdata  = {2'b00, head.tok.err, head.line, head.tok.value};
  assign m_axis_tuser  = {head.tok.quoted, head.tok.kind};
  assign m_axis_tlast  = head.last;

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the property list text tokenizer. A short table of
// hand-picked bytes runs first, then random texts built from whitespace,
// punctuation, words, quoted strings with escapes, comments and noise, some of
// them cut short. Every token on the output is compared with the table's expected
// token or with a behavioral lexer kept in the bench, under several patterns of
// input gaps and output back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
  import ptt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 52;
  localparam int IDLE_PCT [4] = '{0, 69, 0, 20};
  localparam int STALL_PCT [4] = '{0, 0, 69, 20};
  localparam logic [LINE_OUT_BITS-1:0] LINE_MAX = '1;

  // One expected token, with the line count and the run marker it carries
  typedef struct packed {
    token_t                   tok;
    logic [LINE_OUT_BITS-1:0] line;
    logic                     fin;
  } token_expect_t;

  // Directed stimulus; rows with a typed result carry exactly one token
  typedef struct packed {
    logic [7:0]               data;
    logic                     fin;
    logic                     typed;
    logic [2:0]               kind;
    logic [7:0]               value;
    logic [1:0]               err;
    logic [LINE_OUT_BITS-1:0] line;
  } stim_row_t;

  localparam int NUM_ROWS = 28;
  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    '{"{",       1'b0, 1'b1, KIND_PUNCT, "{",   ERR_NONE,    20'd1},
    '{8'h00,     1'b0, 1'b1, KIND_OTHER, 8'h00, ERR_NONE,    20'd1},
    '{8'hFF,     1'b0, 1'b1, KIND_OTHER, 8'hFF, ERR_NONE,    20'd1},
    '{CH_LT,     1'b0, 1'b1, KIND_ERROR, CH_LT, ERR_BINARY,  20'd1},
    '{"a",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{"9",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{" ",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_SLASH,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{"q",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_LF,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_SLASH,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_SLASH,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_LF,     1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{"n",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_BSLASH, 1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_ZERO,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_X,      1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{"f",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{"g",       1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_QUOTE,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_SLASH,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{"Z",       1'b1, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_QUOTE,  1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_QUOTED,  20'd1},
    '{CH_SLASH,  1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_STAR,   1'b0, 1'b0, KIND_DATA,  8'h00, ERR_NONE,    20'd0},
    '{CH_STAR,   1'b1, 1'b1, KIND_ERROR, 8'h00, ERR_COMMENT, 20'd1}
  };

  logic        clk;
  logic        rst;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [3:0]  m_axis_tuser;
  logic        m_axis_tlast;

  // Lexer state mirrored by the bench
  mode_t                    lx_mode;
  logic [LINE_OUT_BITS-1:0] line_cnt;
  logic [7:0]               esc_val;
  logic                     esc_hex;
  logic                     esc_first;

  // Tokens caused by the byte just lexed
  token_t                   step_tok [MAX_RESULTS];
  int                       step_n;

  token_expect_t            pending_tokens [$];
  logic [7:0]               text_q [$];

  int idle_pct;
  int stall_pct;
  int fail_cnt;
  int cycle_cnt;
  int items_sent;
  int live_items;
  int tokens_checked;
  int texts_sent;

  plist_text_tokenizer i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  // Character classes of the lexer
  function automatic bit is_blank(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    return c == "{" || c == "}" || c == "(" || c == ")" || c == "=" || c == ";" ||
           c == ",";
  endfunction

  function automatic int hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c - "0");
    if (c >= "a" && c <= "f") return int'(c - "a") + 10;
    if (c >= "A" && c <= "F") return int'(c - "A") + 10;
    return -1;
  endfunction

  function automatic logic [7:0] esc_code(logic [7:0] c);
    case (c)
      "a":     return 8'h07;
      "b":     return 8'h08;
      "t":     return 8'h09;
      "r":     return 8'h0D;
      "n":     return 8'h0A;
      "v":     return 8'h0B;
      "f":     return 8'h0C;
      default: return c;
    endcase
  endfunction

  function automatic void emit(logic [2:0] kind, logic [7:0] value, logic quoted,
                               logic [1:0] err);
    if (step_n < MAX_RESULTS) begin
      step_tok[step_n] = '{kind: kind, value: value, quoted: quoted, err: err};
      step_n++;
    end
  endfunction

  function automatic void lex_reset();
    lx_mode   = MODE_IDLE;
    line_cnt  = 1;
    esc_val   = '0;
    esc_hex   = 1'b0;
    esc_first = 1'b0;
  endfunction

  // Lex one byte: fill step_tok and return the line count the tokens carry
  function automatic logic [LINE_OUT_BITS-1:0] lex_byte(logic [7:0] c, logic fin);
    int                       pass;
    bit                       again;
    int                       h;
    logic [LINE_OUT_BITS-1:0] line_out;
    step_n = 0;
    if (c == CH_LF && line_cnt < LINE_MAX) line_cnt++;
    pass  = 0;
    again = 1'b1;
    // Re-lex the byte from the new mode when a run, a numeric escape or a lone slash ends on it
    while (again && pass < 3) begin
      again = 1'b0;
      pass++;
      case (lx_mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) lx_mode = MODE_LINE_CMT;
          else if (c == CH_STAR) lx_mode = MODE_BLOCK_CMT;
          else begin
            emit(KIND_OTHER, CH_SLASH, 1'b0, ERR_NONE);
            lx_mode = MODE_IDLE;
            again   = 1'b1;
          end
        end
        MODE_LINE_CMT: begin
          if (c == CH_LF) lx_mode = MODE_IDLE;
        end
        MODE_BLOCK_CMT: begin
          if (c == CH_STAR) lx_mode = MODE_STAR;
        end
        MODE_STAR: begin
          if (c == CH_SLASH) lx_mode = MODE_IDLE;
          else if (c != CH_STAR) lx_mode = MODE_BLOCK_CMT;
        end
        MODE_UNQUOTED: begin
          if (is_alnum(c)) emit(KIND_DATA, c, 1'b0, ERR_NONE);
          else begin
            emit(KIND_END, 8'h00, 1'b0, ERR_NONE);
            lx_mode = MODE_IDLE;
            again   = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (c == CH_BSLASH) lx_mode = MODE_ESC;
          else if (c == CH_QUOTE) begin
            emit(KIND_END, 8'h00, 1'b1, ERR_NONE);
            lx_mode = MODE_IDLE;
          end else emit(KIND_DATA, c, 1'b1, ERR_NONE);
        end
        MODE_ESC: begin
          if (c == CH_ZERO) begin
            esc_val   = '0;
            esc_hex   = 1'b0;
            esc_first = 1'b1;
            lx_mode   = MODE_NUM;
          end else begin
            emit(KIND_DATA, esc_code(c), 1'b1, ERR_NONE);
            lx_mode = MODE_QUOTED;
          end
        end
        MODE_NUM: begin
          h = hex_digit(c);
          if (esc_first && c == CH_X) begin
            esc_hex   = 1'b1;
            esc_first = 1'b0;
          end else if (esc_hex && h >= 0) begin
            esc_val   = {esc_val[3:0], 4'(h)};
            esc_first = 1'b0;
          end else if (c >= CH_ZERO && c <= CH_SEVEN) begin
            esc_val   = {esc_val[4:0], c[2:0]};
            esc_first = 1'b0;
          end else begin
            emit(KIND_DATA, esc_val, 1'b1, ERR_NONE);
            esc_hex   = 1'b0;
            esc_first = 1'b0;
            esc_val   = '0;
            lx_mode   = MODE_QUOTED;
            again     = 1'b1;
          end
        end
        default: begin
          lx_mode = MODE_IDLE;
          if (is_blank(c)) begin
          end else if (c == CH_SLASH) lx_mode = MODE_SLASH;
          else if (c == CH_QUOTE) lx_mode = MODE_QUOTED;
          else if (c == CH_LT) emit(KIND_ERROR, c, 1'b0, ERR_BINARY);
          else if (is_alnum(c)) begin
            emit(KIND_DATA, c, 1'b0, ERR_NONE);
            lx_mode = MODE_UNQUOTED;
          end else if (is_punct(c)) emit(KIND_PUNCT, c, 1'b0, ERR_NONE);
          else emit(KIND_OTHER, c, 1'b0, ERR_NONE);
        end
      endcase
    end
    line_out = line_cnt;
    // Close the text: error inside comments and strings, else flush and end
    if (fin) begin
      if (lx_mode inside {MODE_LINE_CMT, MODE_BLOCK_CMT, MODE_STAR})
        emit(KIND_ERROR, 8'h00, 1'b0, ERR_COMMENT);
      else if (lx_mode inside {MODE_QUOTED, MODE_ESC, MODE_NUM})
        emit(KIND_ERROR, 8'h00, 1'b0, ERR_QUOTED);
      else begin
        if (lx_mode == MODE_SLASH) emit(KIND_OTHER, CH_SLASH, 1'b0, ERR_NONE);
        if (lx_mode == MODE_UNQUOTED) emit(KIND_END, 8'h00, 1'b0, ERR_NONE);
        emit(KIND_EOI, 8'h00, 1'b0, ERR_NONE);
      end
      lex_reset();
    end
    return line_out;
  endfunction

  // Offer one item, wait for its handshake, then queue what it should cause
  task automatic send_byte(input logic [7:0] c, input logic fin, input logic typed,
                           input token_expect_t typed_tok);
    logic [LINE_OUT_BITS-1:0] line_out;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = c;
    s_axis_tlast  = fin;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (!(lx_mode inside {MODE_LINE_CMT, MODE_BLOCK_CMT, MODE_STAR}) &&
        !(lx_mode == MODE_IDLE && is_blank(c)))
      live_items++;
    if (fin) texts_sent++;
    line_out = lex_byte(c, fin);
    if (typed) pending_tokens.push_back(typed_tok);
    else begin
      for (int k = 0; k < step_n; k++)
        pending_tokens.push_back('{tok: step_tok[k], line: line_out, fin: k == step_n - 1});
    end
  endtask

  // Drop valid and hold off until every queued token has come out
  task automatic drain_tokens();
    @(negedge clk);
    s_axis_tvalid = 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
  endtask

  // Build one random text into text_q; some are cut short
  task automatic build_text();
    string alnum = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";
    string puncts = "{}()=;,";
    string hexd = "0123456789abcdefABCDEFgx";
    string escs = "abtrnvfq0x\"\\";
    string cmt = "ab */\n";
    int    n;
    logic [7:0] ch;
    text_q.delete();
    if ($urandom_range(9) == 0) begin
      // Pure noise text
      n = $urandom_range(1, 8);
      repeat (n) text_q.push_back(8'($urandom_range(255)));
    end else begin
      repeat ($urandom_range(2, 8)) begin
        case ($urandom_range(10))
          0, 1: begin
            case ($urandom_range(5))
              0:       text_q.push_back(8'h20);
              1:       text_q.push_back(8'h09);
              2:       text_q.push_back(CH_LF);
              3:       text_q.push_back(8'h0D);
              4:       text_q.push_back(8'h0B);
              default: text_q.push_back(8'h0C);
            endcase
          end
          2: text_q.push_back(puncts[$urandom_range(puncts.len() - 1)]);
          3, 4: begin
            repeat ($urandom_range(1, 6))
              text_q.push_back(alnum[$urandom_range(alnum.len() - 1)]);
          end
          5, 6: begin
            // Quoted string with plain bytes and every kind of escape
            text_q.push_back(CH_QUOTE);
            repeat ($urandom_range(5)) begin
              case ($urandom_range(5))
                0, 1: begin
                  ch = 8'($urandom_range(255));
                  if (ch == CH_QUOTE || ch == CH_BSLASH) ch = "a";
                  text_q.push_back(ch);
                end
                2: begin
                  text_q.push_back(CH_BSLASH);
                  if ($urandom_range(3) == 0) text_q.push_back(8'($urandom_range(255)));
                  else text_q.push_back(escs[$urandom_range(escs.len() - 1)]);
                end
                3: begin
                  text_q.push_back(CH_BSLASH);
                  text_q.push_back(CH_ZERO);
                  repeat ($urandom_range(4))
                    text_q.push_back(CH_ZERO + 8'($urandom_range(7)));
                end
                default: begin
                  text_q.push_back(CH_BSLASH);
                  text_q.push_back(CH_ZERO);
                  text_q.push_back(CH_X);
                  repeat ($urandom_range(3))
                    text_q.push_back(hexd[$urandom_range(hexd.len() - 1)]);
                end
              endcase
            end
            text_q.push_back(CH_QUOTE);
          end
          7: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_SLASH);
            repeat ($urandom_range(6))
              text_q.push_back(alnum[$urandom_range(alnum.len() - 1)]);
            text_q.push_back(CH_LF);
          end
          8: begin
            text_q.push_back(CH_SLASH);
            text_q.push_back(CH_STAR);
            repeat ($urandom_range(6)) text_q.push_back(cmt[$urandom_range(cmt.len() - 1)]);
            text_q.push_back(CH_STAR);
            text_q.push_back(CH_SLASH);
          end
          9: begin
            case ($urandom_range(2))
              0:       text_q.push_back(CH_LT);
              1:       text_q.push_back(CH_SLASH);
              default: text_q.push_back(8'($urandom_range(128, 255)));
            endcase
          end
          default: text_q.push_back(8'($urandom_range(255)));
        endcase
      end
    end
    // Cut some texts short so that some end inside comments or strings
    if ($urandom_range(99) < 20) begin
      n = $urandom_range(1, text_q.size());
      while (text_q.size() > n) void'(text_q.pop_back());
    end
  endtask

  function automatic void check_field(string name, int unsigned exp, int unsigned act);
    if (exp != act) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp, act);
      fail_cnt++;
    end
  endfunction

  // Compare each output token with the oldest expectation
  always @(posedge clk) begin
    token_expect_t exp_tok;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_tokens.size() == 0) begin
        $error("unexpected token: kind %0d value %0d", m_axis_tuser[2:0], m_axis_tdata[7:0]);
        fail_cnt++;
      end else begin
        exp_tok = pending_tokens.pop_front();
        tokens_checked++;
        check_field("token_kind", exp_tok.tok.kind, m_axis_tuser[2:0]);
        check_field("value_byte", exp_tok.tok.value, m_axis_tdata[7:0]);
        check_field("from_quotes", exp_tok.tok.quoted, m_axis_tuser[3]);
        check_field("line_number", exp_tok.line, m_axis_tdata[27:8]);
        check_field("error_code", exp_tok.tok.err, m_axis_tdata[29:28]);
        check_field("run_last", exp_tok.fin, m_axis_tlast);
      end
    end
  end

  // Apply output back-pressure
  always @(negedge clk) begin
    m_axis_tready = ($urandom_range(99) >= stall_pct);
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    token_expect_t typed_tok;
    int            phase_start;
    clk            = 1'b0;
    rst            = 1'b1;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    m_axis_tready  = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    fail_cnt       = 0;
    cycle_cnt      = 0;
    items_sent     = 0;
    live_items     = 0;
    tokens_checked = 0;
    texts_sent     = 0;
    lex_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Walk the directed table
    for (int r = 0; r < NUM_ROWS; r++) begin
      typed_tok = '{tok: '{kind: STIM_ROWS[r].kind, value: STIM_ROWS[r].value,
                           quoted: 1'b0, err: STIM_ROWS[r].err},
                    line: STIM_ROWS[r].line, fin: 1'b1};
      send_byte(STIM_ROWS[r].data, STIM_ROWS[r].fin, STIM_ROWS[r].typed, typed_tok);
    end
    drain_tokens();

    // Random texts under each idling pattern, draining between patterns
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct    = IDLE_PCT[ph];
      stall_pct   = STALL_PCT[ph];
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_ITEMS) begin
        build_text();
        for (int i = 0; i < text_q.size(); i++)
          send_byte(text_q[i], i == text_q.size() - 1, 1'b0, '0);
      end
      drain_tokens();
    end
    repeat (16) @(posedge clk);

    $display("Sent %0d bytes (%0d lexed outside comments and blanks) in %0d texts.",
             items_sent, live_items, texts_sent);
    $display("Checked %0d tokens across four gap and back-pressure patterns.",
             tokens_checked);
    if (fail_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
